// ===== src/i2c_register_transaction_sequencer_assert.svh =====
// ----------------------------------------------------------------------------
// I2C register transaction sequencer assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef I2C_REGISTER_TRANSACTION_SEQUENCER_ASSERT_SVH
`define I2C_REGISTER_TRANSACTION_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset
`define I2CRTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define I2CRTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define I2CRTS_ASSERT_NOW(lbl, ante, cons, msg)
`define I2CRTS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== src/i2crts_pkg.sv =====
// ----------------------------------------------------------------------------
// i2crts_pkg
// Shared types and codes of the I2C register transaction sequencer.
// ----------------------------------------------------------------------------
package i2crts_pkg;

  // Write buffer geometry
  localparam int BUF_DEPTH = 16;
  localparam int BUF_AW    = $clog2(BUF_DEPTH);
  localparam int CNT_W     = 5;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT  = 2'd1;

  // Request kinds
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_REQ    = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;
  localparam logic [1:0] KIND_TICK   = 2'd3;

  // Transaction types
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_PROBE = 2'd2;

  // Controller status codes
  localparam logic [7:0] ST_IDLE      = 8'hF8;
  localparam logic [7:0] ST_START     = 8'h08;
  localparam logic [7:0] ST_RSTART    = 8'h10;
  localparam logic [7:0] ST_ADDRW_ACK = 8'h18;
  localparam logic [7:0] ST_DATA_ACK  = 8'h28;
  localparam logic [7:0] ST_ADDRR_ACK = 8'h40;
  localparam logic [7:0] ST_RD_ACK    = 8'h50;
  localparam logic [7:0] ST_RD_NACK   = 8'h58;

  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       op;
    logic [7:0]       reg_addr;
    logic [CNT_W-1:0] length;
    logic [7:0]       wdata;
    logic [7:0]       status;
    logic             si;
    logic [7:0]       rdata;
  } in_t;

  typedef struct packed {
    logic       cmd_start;
    logic       cmd_stop;
    logic       cmd_ack;
    logic       cmd_launch;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       success;
  } out_t;

  // One step of the sequencer: whether it yields a result, and the result
  typedef struct packed {
    logic fire;
    out_t res;
  } step_t;

endpackage

// ===== src/i2crts_core.sv =====
// ----------------------------------------------------------------------------
// i2crts_core
// Transaction state, write buffer and next-step logic of the sequencer.
// ----------------------------------------------------------------------------
`include "i2c_register_transaction_sequencer_assert.svh"

module i2crts_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               accept,
  input  i2crts_pkg::in_t                    item,
  input  logic                               cfg_we,
  input  logic [i2crts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [i2crts_pkg::CFG_DAT_W-1:0]   cfg_wdata,
  output i2crts_pkg::step_t                  step
);
  import i2crts_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_START, PH_ADDR_W, PH_REG, PH_DATA,
    PH_RSTART, PH_ADDR_R, PH_READ, PH_STOP
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [1:0]       oper_r, oper_nxt;
  logic [7:0]       regaddr_r, regaddr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] index_r, index_nxt;
  logic [15:0]      poll_r, poll_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             failed_r, failed_nxt;
  logic [6:0]       devaddr_r;
  logic [15:0]      tmo_r;
  logic [7:0]       wbuf_r [BUF_DEPTH];

  logic             wbuf_we;
  logic [7:0]       buf_rd;
  logic [15:0]      poll_inc;
  logic [7:0]       addr_w;
  logic             last_rd;
  logic             go_stop, stop_fail, go_finish, finish_ok;
  logic             go_send, go_read, go_rstart;
  logic [7:0]       send_byte;
  phase_t           send_phase;
  out_t             res;
  logic             fire;

  assign buf_rd   = wbuf_r[index_r[BUF_AW-1:0]];
  assign poll_inc = poll_r + 16'd1;
  assign addr_w   = {devaddr_r, 1'b0};
  assign last_rd  = !(({1'b0, index_r} + (CNT_W+1)'(1)) < {1'b0, count_r});
  assign step     = '{fire: fire, res: res};

  // Decide the step for the accepted request
  always_comb begin
    phase_nxt   = phase_r;
    oper_nxt    = oper_r;
    regaddr_nxt = regaddr_r;
    count_nxt   = count_r;
    index_nxt   = index_r;
    poll_nxt    = poll_r;
    fill_nxt    = fill_r;
    failed_nxt  = failed_r;
    wbuf_we     = 1'b0;
    go_stop     = 1'b0;
    stop_fail   = 1'b0;
    go_finish   = 1'b0;
    finish_ok   = 1'b0;
    go_send     = 1'b0;
    go_read     = 1'b0;
    go_rstart   = 1'b0;
    send_byte   = '0;
    send_phase  = PH_IDLE;
    res         = '0;
    fire        = 1'b0;

    if (accept) begin
      unique case (item.kind)
        KIND_LOAD: begin
          if (phase_r == PH_IDLE && fill_r < CNT_W'(BUF_DEPTH)) begin
            wbuf_we  = 1'b1;
            fill_nxt = fill_r + CNT_W'(1);
          end
        end
        KIND_REQ: begin
          if (phase_r == PH_IDLE) begin
            if (item.status != ST_IDLE ||
                (item.op != OP_WRITE && item.op != OP_READ && item.op != OP_PROBE) ||
                (item.op == OP_READ && item.length == '0)) begin
              go_finish = 1'b1;
            end else begin
              oper_nxt    = item.op;
              regaddr_nxt = item.reg_addr;
              if (item.op == OP_PROBE) begin
                count_nxt = CNT_W'(1);
              end else if (item.length > CNT_W'(BUF_DEPTH)) begin
                count_nxt = CNT_W'(BUF_DEPTH);
              end else begin
                count_nxt = item.length;
              end
              index_nxt      = '0;
              fill_nxt       = '0;
              failed_nxt     = 1'b0;
              phase_nxt      = PH_START;
              poll_nxt       = '0;
              res.cmd_start  = 1'b1;
              res.cmd_launch = 1'b1;
              fire           = 1'b1;
            end
          end
        end
        KIND_STATUS, KIND_TICK: begin
          if (phase_r != PH_IDLE) begin
            if (item.kind == KIND_TICK ||
                (phase_r == PH_STOP && item.status != ST_IDLE) ||
                (phase_r != PH_STOP && !item.si)) begin
              // Count one poll, time out at the limit
              poll_nxt = poll_inc;
              if (!(poll_inc < tmo_r)) begin
                if (phase_r == PH_STOP) begin
                  go_finish = 1'b1;
                end else begin
                  go_stop   = 1'b1;
                  stop_fail = 1'b1;
                end
              end
            end else if (phase_r == PH_STOP) begin
              go_finish = 1'b1;
              finish_ok = !failed_r;
            end else begin
              // Check the completion status of the current step
              unique case (phase_r)
                PH_START: begin
                  if (item.status != ST_START) begin
                    go_stop = 1'b1; stop_fail = 1'b1;
                  end else begin
                    go_send    = 1'b1;
                    send_byte  = addr_w | {7'd0, oper_r == OP_PROBE};
                    send_phase = (oper_r == OP_PROBE) ? PH_ADDR_R : PH_ADDR_W;
                  end
                end
                PH_ADDR_W: begin
                  if (item.status != ST_ADDRW_ACK) begin
                    go_stop = 1'b1; stop_fail = 1'b1;
                  end else begin
                    go_send    = 1'b1;
                    send_byte  = regaddr_r;
                    send_phase = PH_REG;
                  end
                end
                PH_REG: begin
                  if (item.status != ST_DATA_ACK) begin
                    go_stop = 1'b1; stop_fail = 1'b1;
                  end else if (oper_r == OP_READ) begin
                    go_rstart = 1'b1;
                  end else if (count_r == '0) begin
                    go_stop = 1'b1;
                  end else begin
                    index_nxt  = CNT_W'(1);
                    go_send    = 1'b1;
                    send_byte  = buf_rd;
                    send_phase = PH_DATA;
                  end
                end
                PH_DATA: begin
                  if (item.status != ST_DATA_ACK) begin
                    go_stop = 1'b1; stop_fail = 1'b1;
                  end else if (index_r < count_r) begin
                    index_nxt  = index_r + CNT_W'(1);
                    go_send    = 1'b1;
                    send_byte  = buf_rd;
                    send_phase = PH_DATA;
                  end else begin
                    go_stop = 1'b1;
                  end
                end
                PH_RSTART: begin
                  if (item.status != ST_RSTART) begin
                    go_stop = 1'b1; stop_fail = 1'b1;
                  end else begin
                    go_send    = 1'b1;
                    send_byte  = addr_w | 8'd1;
                    send_phase = PH_ADDR_R;
                  end
                end
                PH_ADDR_R: begin
                  if (item.status != ST_ADDRR_ACK) begin
                    go_stop = 1'b1; stop_fail = 1'b1;
                  end else begin
                    index_nxt = '0;
                    go_read   = 1'b1;
                  end
                end
                PH_READ: begin
                  if (item.status != (last_rd ? ST_RD_NACK : ST_RD_ACK)) begin
                    go_stop = 1'b1; stop_fail = 1'b1;
                  end else begin
                    if (oper_r == OP_READ) begin
                      res.rx_valid = 1'b1;
                      res.rx_byte  = item.rdata;
                    end
                    index_nxt = index_r + CNT_W'(1);
                    go_stop   = last_rd;
                    go_read   = !last_rd;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        default: ;
      endcase
    end

    // Apply the chosen action
    if (go_send) begin
      phase_nxt      = send_phase;
      poll_nxt       = '0;
      res.tx_valid   = 1'b1;
      res.tx_byte    = send_byte;
      res.cmd_launch = 1'b1;
      fire           = 1'b1;
    end
    if (go_rstart) begin
      phase_nxt      = PH_RSTART;
      poll_nxt       = '0;
      res.cmd_start  = 1'b1;
      res.cmd_launch = 1'b1;
      fire           = 1'b1;
    end
    if (go_read) begin
      phase_nxt      = PH_READ;
      poll_nxt       = '0;
      res.cmd_launch = 1'b1;
      res.cmd_ack    = ({1'b0, index_nxt} + (CNT_W+1)'(1)) < {1'b0, count_r};
      fire           = 1'b1;
    end
    if (go_stop) begin
      failed_nxt     = failed_r | stop_fail;
      phase_nxt      = PH_STOP;
      poll_nxt       = '0;
      res.cmd_stop   = 1'b1;
      res.cmd_launch = 1'b1;
      fire           = 1'b1;
    end
    if (go_finish) begin
      phase_nxt    = PH_IDLE;
      poll_nxt     = '0;
      res.done_res = 1'b1;
      res.success  = finish_ok;
      fire         = 1'b1;
    end
  end

  // Hold transaction state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      oper_r    <= '0;
      regaddr_r <= '0;
      count_r   <= '0;
      index_r   <= '0;
      poll_r    <= '0;
      fill_r    <= '0;
      failed_r  <= 1'b0;
      devaddr_r <= 7'd104;
      tmo_r     <= 16'hFFFF;
    end else begin
      phase_r   <= phase_nxt;
      oper_r    <= oper_nxt;
      regaddr_r <= regaddr_nxt;
      count_r   <= count_nxt;
      index_r   <= index_nxt;
      poll_r    <= poll_nxt;
      fill_r    <= fill_nxt;
      failed_r  <= failed_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DEVICE_ADDRESS: devaddr_r <= cfg_wdata[6:0];
          CFG_TIMEOUT_LIMIT:  tmo_r     <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Append write bytes to the buffer
  always_ff @(posedge clk) begin
    if (wbuf_we) begin
      wbuf_r[fill_r[BUF_AW-1:0]] <= item.wdata;
    end
  end

  `I2CRTS_ASSERT_NEXT(a_done_idle, fire && res.done_res, phase_r == PH_IDLE, "done without return to idle")
  `I2CRTS_ASSERT_NEXT(a_stop_phase, fire && res.cmd_stop, phase_r == PH_STOP, "stop without stop phase")
  `I2CRTS_ASSERT_NOW(a_data_index, phase_r == PH_DATA, index_r <= count_r && index_r != '0, "data index out of range")
  `I2CRTS_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= CNT_W'(BUF_DEPTH), "write buffer overfilled")

endmodule

// ===== src/i2c_register_transaction_sequencer.sv =====
// ----------------------------------------------------------------------------
// i2c_register_transaction_sequencer
// I2C master register write/read/probe sequencer over a byte-level controller.
// ----------------------------------------------------------------------------
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_stall  | in_data  (load, request, status, tick)
//   out_    | output    | out_valid / out_stall| out_data (controller commands, result)
//   cfg_    | input     | cfg_we               | cfg_index, cfg_wdata
//
// One request per cycle while in_stall is low; each request updates the transaction
// state in the cycle it is taken; its result, if any, goes to the output register.
// in_stall is raised only while the output register holds a result that is stalled.
// Reset (rst_n low, synchronous) returns to idle with an empty write buffer.
// ----------------------------------------------------------------------------
`include "i2c_register_transaction_sequencer_assert.svh"

module i2c_register_transaction_sequencer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  i2crts_pkg::in_t                    in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output i2crts_pkg::out_t                   out_data,
  input  logic                               cfg_we,
  input  logic [i2crts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [i2crts_pkg::CFG_DAT_W-1:0]   cfg_wdata
);
  import i2crts_pkg::*;

  logic  accept;
  step_t step;
  logic  out_valid_r, out_valid_nxt;
  out_t  out_data_r;

  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  i2crts_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .step      (step)
  );

  // Load a new result, hold a stalled one, drop a taken one
  always_comb begin
    if (step.fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step.fire) begin
      out_data_r <= step.res;
    end
  end

  `I2CRTS_ASSERT_NOW(a_stall_full, in_stall, out_valid_r, "input stalled with empty output")
  `I2CRTS_ASSERT_NOW(a_fire_room, step.fire, accept && !(out_valid_r && out_stall), "result without room")
  `I2CRTS_ASSERT_NEXT(a_fire_shown, step.fire, out_valid_r, "result not presented")

endmodule
